[rtl/core/stwq_pkg.sv]
package stwq_pkg;

   // Fixed field widths
   localparam int ID_BITS       = 4;
   localparam int ID_SLOTS      = 16;
   localparam int TICK_BITS     = 32;
   localparam int KEY_PORT_BITS = 32;

   // Defaults for the top-level parameters
   localparam int DEFAULT_CAPACITY = 16;
   localparam int DEFAULT_KEY_BITS = 32;

   typedef enum logic [1:0] {
      OP_DEADLINE = 2'd0,
      OP_TIMER    = 2'd1,
      OP_POP      = 2'd2,
      OP_REMOVE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_ZERO_DELAY = 3'd3,
      ST_FULL       = 3'd4,
      ST_ALREADY    = 3'd5
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture the accepted request
      logic commit;  // apply it and write the response register
   } cmd_type;

endpackage

[rtl/core/stwq_ctrl.sv]
module stwq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stwq_pkg::cmd_type cmd
);
   import stwq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_commit;

   // Result slot is free when empty or being drained this cycle
   assign can_commit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (can_commit) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/stwq_datapath.sv]
module stwq_datapath #(
   parameter int CAPACITY = stwq_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = stwq_pkg::DEFAULT_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stwq_pkg::cmd_type                  cmd,
   input  logic [1:0]                         req_operation,
   input  logic [stwq_pkg::ID_BITS-1:0]       req_task_id,
   input  logic [stwq_pkg::TICK_BITS-1:0]     req_deadline_key,
   input  logic [stwq_pkg::TICK_BITS-1:0]     req_delay_ticks,
   input  logic [stwq_pkg::TICK_BITS-1:0]     req_now_tick,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_taken_valid,
   output logic [stwq_pkg::ID_BITS-1:0]       rsp_taken_id,
   output logic [stwq_pkg::KEY_PORT_BITS-1:0] rsp_taken_key,
   output logic                               rsp_head_valid,
   output logic [stwq_pkg::ID_BITS-1:0]       rsp_head_id,
   output logic [stwq_pkg::KEY_PORT_BITS-1:0] rsp_head_key,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_queued
);
   import stwq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // Captured request
   op_type               op_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic                 zero_ff;
   logic [TICK_BITS:0]   timer_sum;
   logic [KEY_BITS-1:0]  key_sel;

   // Sorted entry row
   logic [ID_BITS-1:0]   ids_ff  [CAPACITY];
   logic [KEY_BITS-1:0]  keys_ff [CAPACITY];
   logic [ID_BITS-1:0]   ids_in  [CAPACITY];
   logic [KEY_BITS-1:0]  keys_in [CAPACITY];
   logic [CW-1:0]        count_ff, count_in;
   logic [ID_SLOTS-1:0]  present_ff, present_in;

   logic [CAPACITY-1:0]  le;     // entry key <= new key
   logic [CAPACITY-1:0]  match;  // entry holds the named task
   logic [CAPACITY-1:0]  gone;   // at or past the removed entry

   status_type           status;
   logic                 do_insert, do_shift, is_pop;

   assign timer_sum = {1'b0, req_now_tick} + {1'b0, req_delay_ticks};
   assign key_sel   = (op_type'(req_operation) == OP_TIMER) ? KEY_BITS'(timer_sum)
                                                             : KEY_BITS'(req_deadline_key);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_operation);
         id_ff   <= req_task_id;
         key_ff  <= key_sel;
         zero_ff <= (req_delay_ticks == '0);
      end
   end

   // Per-cell compare and shift
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic valid;
      assign valid    = CW'(i) < count_ff;
      assign le[i]    = valid && (keys_ff[i] <= key_ff);
      assign match[i] = valid && (ids_ff[i] == id_ff);

      logic               take_new;
      logic [ID_BITS-1:0] ins_id, shl_id;
      logic [KEY_BITS-1:0] ins_key, shl_key;

      if (i == 0) begin : g_head
         assign gone[i]  = match[i];
         assign take_new = 1'b1;
         assign ins_id   = id_ff;
         assign ins_key  = key_ff;
      end else begin : g_body
         assign gone[i]  = gone[i-1] | match[i];
         assign take_new = le[i-1];
         assign ins_id   = take_new ? id_ff  : ids_ff[i-1];
         assign ins_key  = take_new ? key_ff : keys_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign shl_id  = ids_ff[i];
         assign shl_key = keys_ff[i];
      end else begin : g_mid
         assign shl_id  = ids_ff[i+1];
         assign shl_key = keys_ff[i+1];
      end

      always_comb begin
         ids_in[i]  = ids_ff[i];
         keys_in[i] = keys_ff[i];
         if (do_insert && !le[i]) begin
            ids_in[i]  = ins_id;
            keys_in[i] = ins_key;
         end else if (do_shift && (is_pop || gone[i])) begin
            ids_in[i]  = shl_id;
            keys_in[i] = shl_key;
         end
      end
   end

   // Operation decode
   always_comb begin
      status     = ST_OK;
      do_insert  = 1'b0;
      do_shift   = 1'b0;
      is_pop     = 1'b0;
      count_in   = count_ff;
      present_in = present_ff;
      unique case (op_ff) inside
         OP_DEADLINE, OP_TIMER: begin
            if (op_ff == OP_TIMER && zero_ff) begin
               status = ST_ZERO_DELAY;
            end else if (present_ff[id_ff]) begin
               status = ST_ALREADY;
            end else if (count_ff == CW'(CAPACITY)) begin
               status = ST_FULL;
            end else begin
               do_insert         = 1'b1;
               count_in          = count_ff + CW'(1);
               present_in[id_ff] = 1'b1;
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               do_shift              = 1'b1;
               is_pop                = 1'b1;
               count_in              = count_ff - CW'(1);
               present_in[ids_ff[0]] = 1'b0;
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (!present_ff[id_ff]) begin
               status = ST_NOT_FOUND;
            end else begin
               do_shift          = 1'b1;
               count_in          = count_ff - CW'(1);
               present_in[id_ff] = 1'b0;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         present_ff <= '0;
      end else if (cmd.commit) begin
         count_ff   <= count_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = 0; i < CAPACITY; i++) begin
            ids_ff[i]  <= ids_in[i];
            keys_ff[i] <= keys_in[i];
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status      <= status;
         rsp_taken_valid <= is_pop;
         rsp_taken_id    <= is_pop ? ids_ff[0] : '0;
         rsp_taken_key   <= is_pop ? KEY_PORT_BITS'(keys_ff[0]) : '0;
         rsp_head_valid  <= (count_in != '0);
         rsp_head_id     <= (count_in != '0) ? ids_in[0] : '0;
         rsp_head_key    <= (count_in != '0) ? KEY_PORT_BITS'(keys_in[0]) : '0;
         rsp_queued      <= count_in;
      end
   end

endmodule

[rtl/core/sorted_task_wait_queue_top.sv]
// Sorted task wait queue: task ids held in ascending key order, equal keys FIFO.
// Flow: capture at the accepting edge, then apply and register the response
//   once the output register is free. One request in flight; the next request is
//   taken while a response still waits in the output register.
// Reset (synchronous, active high) empties the queue and clears the present map.
module sorted_task_wait_queue_top #(
   parameter int CAPACITY = stwq_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = stwq_pkg::DEFAULT_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic [stwq_pkg::ID_BITS-1:0]       req_task_id,
   input  logic [stwq_pkg::TICK_BITS-1:0]     req_deadline_key,
   input  logic [stwq_pkg::TICK_BITS-1:0]     req_delay_ticks,
   input  logic [stwq_pkg::TICK_BITS-1:0]     req_now_tick,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_taken_valid,
   output logic [stwq_pkg::ID_BITS-1:0]       rsp_taken_id,
   output logic [stwq_pkg::KEY_PORT_BITS-1:0] rsp_taken_key,
   output logic                               rsp_head_valid,
   output logic [stwq_pkg::ID_BITS-1:0]       rsp_head_id,
   output logic [stwq_pkg::KEY_PORT_BITS-1:0] rsp_head_key,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_queued
);
   import stwq_pkg::*;

   cmd_type cmd;

   // Controller: accepts a request in idle, moves to exec and applies it there as
   // soon as the response register is free or being drained.
   stwq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: a row of cells, each comparing its key with the new one and
   // shifting right on insert or left on pop/remove.
   stwq_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_operation),
      .req_task_id      (req_task_id),
      .req_deadline_key (req_deadline_key),
      .req_delay_ticks  (req_delay_ticks),
      .req_now_tick     (req_now_tick),
      .rsp_status       (rsp_status),
      .rsp_taken_valid  (rsp_taken_valid),
      .rsp_taken_id     (rsp_taken_id),
      .rsp_taken_key    (rsp_taken_key),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_head_id      (rsp_head_id),
      .rsp_head_key     (rsp_head_key),
      .rsp_queued       (rsp_queued)
   );

endmodule

[rtl/core/stwq_checker.sv]
module stwq_checker #(
   parameter int CAPACITY = stwq_pkg::DEFAULT_CAPACITY
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [2:0]                         rsp_status,
   input logic                               rsp_taken_valid,
   input logic                               rsp_head_valid,
   input logic [$clog2(CAPACITY+1)-1:0]      rsp_queued
);
   import stwq_pkg::*;

   // One request in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_queued)))
      else $error("stalled response changed");

   // Head valid tracks a nonempty count
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_queued != '0)))
      else $error("head valid disagrees with count");

   // Count never exceeds capacity
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queued <= ($clog2(CAPACITY+1))'(CAPACITY)))
      else $error("count above capacity");

   // A popped entry only comes with an ok status
   a_taken_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_taken_valid) |-> (rsp_status == ST_OK))
      else $error("taken entry without ok status");

endmodule

bind sorted_task_wait_queue_top stwq_checker #(.CAPACITY(CAPACITY)) u_stwq_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import stwq_pkg::*;

   localparam int CAPACITY = 16;

   // One response as the queue should report it
   typedef struct {
      status_type  status;
      logic        taken_valid;
      logic [3:0]  taken_id;
      logic [31:0] taken_key;
      logic        head_valid;
      logic [3:0]  head_id;
      logic [31:0] head_key;
      logic [4:0]  queued;
   } queue_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_POP;
   logic [3:0]  req_task_id = '0;
   logic [31:0] req_deadline_key = '0;
   logic [31:0] req_delay_ticks = '0;
   logic [31:0] req_now_tick = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_taken_valid;
   logic [3:0]  rsp_taken_id;
   logic [31:0] rsp_taken_key;
   logic        rsp_head_valid;
   logic [3:0]  rsp_head_id;
   logic [31:0] rsp_head_key;
   logic [4:0]  rsp_queued;

   // Shadow copy of the sorted queue, advanced at each accepted request
   logic [3:0]  shadow_ids [CAPACITY];
   logic [31:0] shadow_keys [CAPACITY];
   int unsigned shadow_count = 0;
   bit          shadow_present [16];

   // Responses still owed by the block, oldest first
   queue_outcome_type owed_responses[$];

   int  mismatch_total = 0;
   bit  quiet_tail = 1'b0;   // no idling on either side in the closing stretch
   int  op_seen [4];
   int  status_seen [6];
   int  deepest = 0;

   sorted_task_wait_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_task_id      (req_task_id),
      .req_deadline_key (req_deadline_key),
      .req_delay_ticks  (req_delay_ticks),
      .req_now_tick     (req_now_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_taken_valid  (rsp_taken_valid),
      .rsp_taken_id     (rsp_taken_id),
      .rsp_taken_key    (rsp_taken_key),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_head_id      (rsp_head_id),
      .rsp_head_key     (rsp_head_key),
      .rsp_queued       (rsp_queued)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", owed_responses.size());
      $display("tb_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow queue
   // ------------------------------------------------------------------

   // Close the gap at pos by shifting the tail forward
   function automatic void drop_at(int unsigned pos);
      for (int unsigned j = pos; j + 1 < shadow_count; j++) begin
         shadow_ids[j]  = shadow_ids[j + 1];
         shadow_keys[j] = shadow_keys[j + 1];
      end
      shadow_count--;
   endfunction

   // Insert behind every entry with a key <= key, so equal keys stay FIFO.
   // Duplicate check precedes the capacity check.
   function automatic status_type insert_entry(logic [3:0] id, logic [31:0] key);
      int unsigned pos;
      if (shadow_present[id])
         return ST_ALREADY;
      if (shadow_count >= CAPACITY)
         return ST_FULL;
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] <= key)
         pos++;
      for (int unsigned j = shadow_count; j > pos; j--) begin
         shadow_ids[j]  = shadow_ids[j - 1];
         shadow_keys[j] = shadow_keys[j - 1];
      end
      shadow_ids[pos]    = id;
      shadow_keys[pos]   = key;
      shadow_present[id] = 1'b1;
      shadow_count++;
      return ST_OK;
   endfunction

   // Apply one request to the shadow queue and return the response it owes
   function automatic queue_outcome_type queue_step(op_type op, logic [3:0] id,
         logic [31:0] dl, logic [31:0] dly, logic [31:0] now);
      queue_outcome_type o;
      int hit;
      o.status      = ST_OK;
      o.taken_valid = 1'b0;
      o.taken_id    = '0;
      o.taken_key   = '0;
      hit           = -1;
      case (op)
         OP_DEADLINE: o.status = insert_entry(id, dl);
         OP_TIMER: begin
            // zero delay is rejected before anything else; key wraps at 32 bits
            if (dly == 0)
               o.status = ST_ZERO_DELAY;
            else
               o.status = insert_entry(id, now + dly);
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.taken_valid = 1'b1;
               o.taken_id    = shadow_ids[0];
               o.taken_key   = shadow_keys[0];
               shadow_present[shadow_ids[0]] = 1'b0;
               drop_at(0);
            end
         end
         default: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < shadow_count; i++)
                  if (hit < 0 && shadow_ids[i] == id)
                     hit = i;
               if (hit < 0) begin
                  o.status = ST_NOT_FOUND;
               end else begin
                  shadow_present[id] = 1'b0;
                  drop_at(hit);
               end
            end
         end
      endcase
      o.head_valid = (shadow_count != 0);
      o.head_id    = o.head_valid ? shadow_ids[0] : 4'd0;
      o.head_key   = o.head_valid ? shadow_keys[0] : 32'd0;
      o.queued     = shadow_count[4:0];
      op_seen[op]++;
      status_seen[o.status]++;
      if (shadow_count > deepest)
         deepest = shadow_count;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Valid is left high on return so a back-to-back request only updates the
   // payload in the next call.
   task automatic send_request(op_type op, logic [3:0] id, logic [31:0] dl,
         logic [31:0] dly, logic [31:0] now);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_task_id      <= id;
      req_deadline_key <= dl;
      req_delay_ticks  <= dly;
      req_now_tick     <= now;
      do @(posedge clock); while (req_ready !== 1'b1);
      owed_responses.push_back(queue_step(op, id, dl, dly, now));
   endtask

   // Hold off new requests until every owed response has been seen
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_responses.size() != 0);
   endtask

   // Random traffic with a weighted mix of inserts, pops and removes
   task automatic random_run(int n, int w_insert, int w_pop, int w_remove);
      int unsigned pick;
      op_type      op;
      logic [3:0]  id;
      logic [31:0] dl, dly, now;
      repeat (n) begin
         pick = $urandom_range(0, w_insert + w_pop + w_remove - 1);
         id   = 4'($urandom_range(0, 15));
         dl   = $urandom;
         dly  = $urandom;
         now  = $urandom;
         if (pick < w_insert) begin
            op = ($urandom_range(0, 1) == 0) ? OP_DEADLINE : OP_TIMER;
            // tight key ranges give lots of equal keys
            if ($urandom_range(0, 1) == 0) begin
               dl  = $urandom_range(0, 7);
               now = $urandom_range(0, 4);
               dly = $urandom_range(1, 3);
            end
            if ($urandom_range(0, 9) == 0)
               dly = '0;
         end else if (pick < w_insert + w_pop) begin
            op = OP_POP;
         end else begin
            op = OP_REMOVE;
            // mostly name a queued task so removals actually land
            if (shadow_count != 0 && $urandom_range(0, 3) != 0)
               id = shadow_ids[$urandom_range(0, shadow_count - 1)];
         end
         send_request(op, id, dl, dly, now);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_empty_queue();
      send_request(OP_POP, 4'd0, '0, '0, '0);
      send_request(OP_REMOVE, 4'hF, '1, '1, '1);
      send_request(OP_TIMER, 4'd2, '1, '0, '1);          // zero delay
   endtask

   task automatic test_deadline_order();
      send_request(OP_DEADLINE, 4'd3, 32'hFFFF_FFFF, '0, '0);
      send_request(OP_DEADLINE, 4'd5, 32'h0, '1, '1);     // new head
      send_request(OP_DEADLINE, 4'd7, 32'd100, '0, '0);
      send_request(OP_DEADLINE, 4'd9, 32'd100, '0, '0);   // ties go behind
      send_request(OP_DEADLINE, 4'd0, 32'd100, '0, '0);
      send_request(OP_DEADLINE, 4'd7, 32'd1, '0, '0);     // already queued
      send_request(OP_REMOVE, 4'd12, '0, '0, '0);         // not queued
      send_request(OP_REMOVE, 4'd9, '0, '0, '0);          // from the middle
      send_request(OP_REMOVE, 4'd5, '0, '0, '0);          // the head
   endtask

   task automatic test_timer_insert();
      send_request(OP_TIMER, 4'd12, '0, 32'h20, 32'hFFFF_FFF0);  // key wraps to 0x10
      send_request(OP_TIMER, 4'd1, '0, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_TIMER, 4'd14, '1, 32'h0, 32'd100);          // zero delay
      send_request(OP_TIMER, 4'd15, '0, 32'd1, 32'd99);           // ties with 100
      send_request(OP_TIMER, 4'd12, '0, 32'd5, 32'd5);            // already queued
   endtask

   // Pop everything out in key order, then once more on the empty queue
   task automatic test_pop_order();
      repeat (7) send_request(OP_POP, 4'($urandom_range(0, 15)), $urandom, $urandom,
         $urandom);
   endtask

   task automatic test_random_mixed();
      random_run(150, 2, 1, 1);
   endtask

   // Insert-heavy: drives the queue to its full depth. With 16 ids and 16
   // slots a full queue only sees duplicate inserts, so the full status
   // stays out of reach here.
   task automatic test_random_fill();
      random_run(100, 6, 1, 1);
   endtask

   task automatic test_random_drain();
      random_run(80, 1, 3, 3);
   endtask

   task automatic test_steady_stream();
      quiet_tail = 1'b1;
      random_run(120, 2, 1, 1);
   endtask

   // ------------------------------------------------------------------
   // Response checker
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (owed_responses.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("%0t: response with no request outstanding", $realtime);
         end else begin
            want = owed_responses.pop_front();
            if (rsp_status !== want.status || rsp_taken_valid !== want.taken_valid ||
                  rsp_taken_id !== want.taken_id || rsp_taken_key !== want.taken_key ||
                  rsp_head_valid !== want.head_valid || rsp_head_id !== want.head_id ||
                  rsp_head_key !== want.head_key || rsp_queued !== want.queued) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("%0t: mismatch", $realtime);
                  $display("  exp st %0d taken %b/%h/%h head %b/%h/%h n %0d",
                     want.status, want.taken_valid, want.taken_id, want.taken_key,
                     want.head_valid, want.head_id, want.head_key, want.queued);
                  $display("  got st %0d taken %b/%h/%h head %b/%h/%h n %0d",
                     rsp_status, rsp_taken_valid, rsp_taken_id, rsp_taken_key,
                     rsp_head_valid, rsp_head_id, rsp_head_key, rsp_queued);
               end
            end
         end
      end
   end

   // Receiver: random stall bursts, with runs of steady ready in between
   initial begin
      @(posedge clock);
      forever begin
         if (quiet_tail || $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_deadline_order();
      test_timer_insert();
      test_pop_order();
      test_random_mixed();
      test_random_fill();
      wait_drained();          // sender holds until the block is caught up
      test_random_drain();
      test_steady_stream();

      wait_drained();
      repeat (8) @(posedge clock);   // catch any stray response

      $display("covered %0d requests: %0d deadline, %0d timer, %0d pop, %0d remove;"
         , op_seen[OP_DEADLINE] + op_seen[OP_TIMER] + op_seen[OP_POP] + op_seen[OP_REMOVE]
         , op_seen[OP_DEADLINE], op_seen[OP_TIMER], op_seen[OP_POP], op_seen[OP_REMOVE]);
      $display("deepest %0d; ok %0d empty %0d not-found %0d zero-delay %0d dup %0d",
         deepest, status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
         status_seen[ST_ZERO_DELAY], status_seen[ST_ALREADY]);
      if (mismatch_total == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d failures", mismatch_total);
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/stwq_pkg.sv
rtl/core/stwq_ctrl.sv
rtl/core/stwq_datapath.sv
rtl/core/sorted_task_wait_queue_top.sv
rtl/core/stwq_checker.sv
tb/tb_top.sv
